FILE: rtl/wspr_symbol_transmit_sequencer_defines.svh
// ---------------------------------------------------------------------------
// assertion macros for the transmit sequencer
// ---------------------------------------------------------------------------
`ifndef WSPR_SYMBOL_TRANSMIT_SEQUENCER_DEFINES_SVH
`define WSPR_SYMBOL_TRANSMIT_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define WSTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wsts_pkg.sv
// ---------------------------------------------------------------------------
// wsts_pkg
// types, codes and constants shared by the transmit sequencer modules
// ---------------------------------------------------------------------------
package wsts_pkg;

    localparam int MESSAGE_LENGTH = 162;
    localparam int IDX_W = (MESSAGE_LENGTH > 1) ? $clog2(MESSAGE_LENGTH) : 1;
    localparam int PTR_W = $clog2(MESSAGE_LENGTH + 1);

    localparam logic [29:0] FREQ_MAX = 30'd1065539394;

    // floor(x / 1000) = (x * DIV_MUL) >> DIV_SHIFT, exact for any 32-bit x
    localparam logic [28:0] DIV_MUL = 29'd274877907;
    localparam int DIV_SHIFT = 38;

    // register indexes
    localparam logic [1:0] REG_BASE_FREQ = 2'd0;
    localparam logic [1:0] REG_OFFSET_FREQ = 2'd1;
    localparam logic [1:0] REG_SYMBOL_DUR = 2'd2;
    localparam logic [1:0] REG_CYCLE_SEC = 2'd3;

    localparam logic [29:0] RST_BASE_FREQ = 30'd0;
    localparam logic [15:0] RST_OFFSET_FREQ = 16'd1500;
    localparam logic [15:0] RST_SYMBOL_DUR = 16'd682;
    localparam logic [11:0] RST_CYCLE_SEC = 12'd240;
    localparam logic [39:0] RST_BASE_MHZ = 40'd1500000;
    localparam logic [21:0] RST_CYCLE_MS = 22'd240000;

    // reported state codes
    localparam logic [1:0] TX_CODE_IDLE = 2'd0;
    localparam logic [1:0] TX_CODE_TX = 2'd1;
    localparam logic [1:0] TX_CODE_WAIT = 2'd2;

    typedef enum logic [1:0] {
        FUNC_POLL  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2,
        FUNC_LOAD  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TX   = 3'b010,
        ST_WAIT = 3'b100
    } t_state;

    typedef struct packed {
        logic [39:0] base_mhz;
        logic [15:0] dur_ms;
        logic [21:0] cycle_ms;
        logic        busy;
    } t_cfg;

    typedef struct packed {
        t_func       func;
        logic [31:0] now_ms;
        logic [7:0]  idx;
        logic [1:0]  val;
        logic        done;
    } t_item;

    typedef struct packed {
        logic        en;
        logic        upd;
        logic [29:0] freq;
        logic [1:0]  state;
        logic [31:0] diff;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [1:0]       data;
    } t_store_wr;

    function automatic logic [12:0] tone_mhz(logic [1:0] tone);
        logic [12:0] v;
        case (tone)
            2'd0: v = 13'd0;
            2'd1: v = 13'd1465;
            2'd2: v = 13'd2930;
            2'd3: v = 13'd4394;
            default: v = 13'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/wspr_symbol_transmit_sequencer.sv
// ---------------------------------------------------------------------------
// wspr_symbol_transmit_sequencer
// 4-fsk beacon transmit sequencer with stream ports and apb settings
// ---------------------------------------------------------------------------
// a result goes through the input, sequencer result and output registers in turn
// throughput: one item per cycle, set by the state update stage, unless the output stalls
// or a settings write holds item processing while the derived products settle
// reset (synchronous, active low): idle, carrier off, settings to defaults
// the symbol memory is not cleared by reset
module wspr_symbol_transmit_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // now_ms, symbol_index, symbol_value, zero pad
    input  logic [1:0]  s_axis_tuser,  // func
    input  logic        s_axis_tlast,  // load_done
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // carrier_enable, freq_millihz, tx_state, cycle_second
    output logic        m_axis_tuser,  // freq_update
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wsts_pkg::*;

    t_cfg             w_cfg;
    t_item            r_in;
    logic             r_v0;
    logic             r_v1;
    logic             r_v2;
    logic             w_ld1;
    logic             w_ld2;
    logic             w_free1;
    logic             w_free0;
    t_store_wr        w_wr;
    logic [IDX_W-1:0] w_rd_addr;
    logic [1:0]       w_sym;
    t_result          w_res;
    logic [60:0]      w_prod;
    logic             r_out_en;
    logic             r_out_upd;
    logic [29:0]      r_out_freq;
    logic [1:0]       r_out_state;
    logic [22:0]      r_out_sec;

    wsts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wsts_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_sym     (w_sym)
    );

    wsts_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ld      (w_ld1),
        .i_item    (r_in),
        .i_cfg     (w_cfg),
        .i_sym     (w_sym),
        .o_wr      (w_wr),
        .o_rd_addr (w_rd_addr),
        .o_res     (w_res)
    );

    // a stage moves when the next is empty or moving; the first also waits on busy
    assign w_ld2 = r_v1 && (!r_v2 || m_axis_tready);
    assign w_free1 = !r_v1 || w_ld2;
    assign w_ld1 = r_v0 && w_free1 && !w_cfg.busy;
    assign w_free0 = !r_v0 || w_ld1;
    assign s_axis_tready = w_free0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_free0) begin
                r_v0 <= s_axis_tvalid;
            end
            if (w_free1) begin
                r_v1 <= w_ld1;
            end
            if (!r_v2 || m_axis_tready) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free0 && s_axis_tvalid) begin
            r_in.func <= t_func'(s_axis_tuser);
            r_in.now_ms <= s_axis_tdata[31:0];
            r_in.idx <= s_axis_tdata[39:32];
            r_in.val <= s_axis_tdata[41:40];
            r_in.done <= s_axis_tlast;
        end
    end

    // seconds since cycle start: divide by 1000 through reciprocal multiply
    assign w_prod = 61'(w_res.diff) * 61'(DIV_MUL);

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_out_en <= w_res.en;
            r_out_upd <= w_res.upd;
            r_out_freq <= w_res.freq;
            r_out_state <= w_res.state;
            r_out_sec <= w_prod[DIV_SHIFT +: 23];
        end
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tuser = r_out_upd;
    assign m_axis_tdata = {r_out_sec, r_out_state, r_out_freq, r_out_en};

endmodule

FILE: rtl/wsts_cfg.sv
// ---------------------------------------------------------------------------
// wsts_cfg
// apb register file plus registered products derived from the settings
// ---------------------------------------------------------------------------
module wsts_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output wsts_pkg::t_cfg  o_cfg
);
    import wsts_pkg::*;

    logic [29:0] r_base_freq;
    logic [15:0] r_offset_freq;
    logic [15:0] r_symbol_dur;
    logic [11:0] r_cycle_sec;
    logic [39:0] r_base_mhz;
    logic [21:0] r_cycle_ms;
    logic        r_busy;
    logic        w_wr;
    logic [1:0]  w_reg;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign w_reg = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_freq <= RST_BASE_FREQ;
            r_offset_freq <= RST_OFFSET_FREQ;
            r_symbol_dur <= RST_SYMBOL_DUR;
            r_cycle_sec <= RST_CYCLE_SEC;
            r_base_mhz <= RST_BASE_MHZ;
            r_cycle_ms <= RST_CYCLE_MS;
            r_busy <= 1'b0;
        end else begin
            r_busy <= w_wr;
            r_base_mhz <= 40'((31'(r_base_freq) + 31'(r_offset_freq)) * 41'd1000);
            r_cycle_ms <= 22'(r_cycle_sec * 22'd1000);
            if (w_wr) begin
                case (w_reg)
                    REG_BASE_FREQ: r_base_freq <= pwdata[29:0];
                    REG_OFFSET_FREQ: r_offset_freq <= pwdata[15:0];
                    REG_SYMBOL_DUR: r_symbol_dur <= pwdata[15:0];
                    REG_CYCLE_SEC: r_cycle_sec <= pwdata[11:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (w_reg)
            REG_BASE_FREQ: prdata = 32'(r_base_freq);
            REG_OFFSET_FREQ: prdata = 32'(r_offset_freq);
            REG_SYMBOL_DUR: prdata = 32'(r_symbol_dur);
            REG_CYCLE_SEC: prdata = 32'(r_cycle_sec);
            default: prdata = 32'd0;
        endcase
    end

    // derived products are registered from the settings, busy covers the gap after a write
    assign o_cfg.base_mhz = r_base_mhz;
    assign o_cfg.dur_ms = r_symbol_dur;
    assign o_cfg.cycle_ms = r_cycle_ms;
    assign o_cfg.busy = r_busy || w_wr;

endmodule

FILE: rtl/wsts_store.sv
// ---------------------------------------------------------------------------
// wsts_store
// symbol memory, one write and one registered read port, write forwarding
// ---------------------------------------------------------------------------
module wsts_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wsts_pkg::t_store_wr           i_wr,
    input  logic [wsts_pkg::IDX_W-1:0]    i_rd_addr,
    output logic [1:0]                    o_sym
);
    import wsts_pkg::*;

    logic [1:0] r_mem [0:MESSAGE_LENGTH-1];
    logic [1:0] r_rd_data;
    logic [1:0] r_fwd_data;
    logic       r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_fwd_data <= i_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= i_wr.we && (i_wr.addr == i_rd_addr);
        end
    end

    assign o_sym = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

FILE: rtl/wsts_seq.sv
// ---------------------------------------------------------------------------
// wsts_seq
// transmit state machine, one item per cycle while i_ld is high, with its result register
// ---------------------------------------------------------------------------
module wsts_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ld,
    input  wsts_pkg::t_item               i_item,
    input  wsts_pkg::t_cfg                i_cfg,
    input  logic [1:0]                    i_sym,
    output wsts_pkg::t_store_wr           o_wr,
    output logic [wsts_pkg::IDX_W-1:0]    o_rd_addr,
    output wsts_pkg::t_result             o_res
);
    import wsts_pkg::*;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [31:0]      r_cyc_start, n_cyc_start;
    logic [31:0]      r_sym_start, n_sym_start;
    logic             r_rdy, n_rdy;
    logic             r_en, n_en;
    t_result          r_res, n_res;

    logic [31:0]      w_cyc_diff;
    logic [31:0]      w_sym_diff;
    logic [40:0]      w_sum;
    logic [29:0]      w_freq;
    logic [PTR_W:0]   w_ptr_inc;

    assign w_cyc_diff = i_item.now_ms - r_cyc_start;
    assign w_sym_diff = i_item.now_ms - r_sym_start;
    assign w_sum = 41'(i_cfg.base_mhz) + 41'(tone_mhz(i_sym));
    assign w_freq = (w_sum > 41'(FREQ_MAX)) ? FREQ_MAX : w_sum[29:0];
    assign w_ptr_inc = (PTR_W + 1)'(r_ptr) + 1'b1;

    always_comb begin
        n_state = r_state;
        n_ptr = r_ptr;
        n_cyc_start = r_cyc_start;
        n_sym_start = r_sym_start;
        n_rdy = r_rdy;
        n_en = r_en;
        o_wr.we = 1'b0;
        o_wr.addr = i_item.idx[IDX_W-1:0];
        o_wr.data = i_item.val;
        n_res.upd = 1'b0;
        n_res.freq = 30'd0;
        if (i_ld) begin
            case (i_item.func)
                FUNC_START: begin
                    n_state = ST_TX;
                    n_ptr = '0;
                    n_cyc_start = i_item.now_ms;
                    n_en = 1'b1;
                end
                FUNC_STOP: begin
                    n_en = 1'b0;
                    n_state = ST_IDLE;
                end
                FUNC_LOAD: begin
                    o_wr.we = (int'(i_item.idx) < MESSAGE_LENGTH);
                    if (i_item.done) begin
                        n_rdy = 1'b1;
                    end
                end
                FUNC_POLL: begin
                    case (r_state)
                        ST_WAIT: begin
                            if (w_cyc_diff > 32'(i_cfg.cycle_ms)) begin
                                n_state = ST_TX;
                                n_ptr = '0;
                                n_cyc_start = i_item.now_ms;
                                n_en = 1'b1;
                            end
                        end
                        ST_TX: begin
                            if (!r_rdy) begin
                                n_state = ST_WAIT;
                            end else if (r_ptr == '0 ||
                                         w_sym_diff >= 32'(i_cfg.dur_ms)) begin
                                n_sym_start = i_item.now_ms;
                                n_res.upd = 1'b1;
                                n_res.freq = w_freq;
                                n_ptr = w_ptr_inc[PTR_W-1:0];
                                if (int'(w_ptr_inc) >= MESSAGE_LENGTH) begin
                                    n_en = 1'b0;
                                    n_state = ST_WAIT;
                                end
                            end
                        end
                        ST_IDLE: ;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        n_res.en = n_en;
        case (n_state)
            ST_TX: n_res.state = TX_CODE_TX;
            ST_WAIT: n_res.state = TX_CODE_WAIT;
            default: n_res.state = TX_CODE_IDLE;
        endcase
        n_res.diff = i_item.now_ms - n_cyc_start;
    end

    // memory read is addressed with the next pointer, so its registered data matches r_ptr
    assign o_rd_addr = (int'(n_ptr) < MESSAGE_LENGTH) ? n_ptr[IDX_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr <= '0;
            r_cyc_start <= 32'd0;
            r_sym_start <= 32'd0;
            r_rdy <= 1'b0;
            r_en <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr <= n_ptr;
            r_cyc_start <= n_cyc_start;
            r_sym_start <= n_sym_start;
            r_rdy <= n_rdy;
            r_en <= n_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/wsts_port_checker.sv
// ---------------------------------------------------------------------------
// wsts_port_checker
// port-level checks on the result stream of the transmit sequencer
// ---------------------------------------------------------------------------
`include "wspr_symbol_transmit_sequencer_defines.svh"

module wsts_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import wsts_pkg::*;

    `WSTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    `WSTS_ASSERT_NOW(a_freq_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[30:1] == 30'd0, "frequency without tone step")

    `WSTS_ASSERT_NOW(a_idle_off, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[32:31] == TX_CODE_IDLE), !m_axis_tdata[0], "carrier on while idle")

    `WSTS_ASSERT_NOW(a_upd_active, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[32:31] == TX_CODE_TX) || (m_axis_tdata[32:31] == TX_CODE_WAIT), "tone step outside transmission")

endmodule

bind wspr_symbol_transmit_sequencer wsts_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/wsts_result_checker.sv
// ---------------------------------------------------------------------------
// wsts_result_checker
// watches the item, report and settings channels of the transmit sequencer,
// predicts every report from the accepted items and compares field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsts_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // now_ms, symbol_index, symbol_value, zero pad
    input  logic [1:0]  s_axis_tuser,  // func
    input  logic        s_axis_tlast,  // load_done
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,  // carrier_enable, freq_millihz, tx_state, cycle_second
    input  logic        m_axis_tuser,  // freq_update
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_mismatches,
    output int          o_pending
);
    import wsts_pkg::*;

    typedef struct packed {
        logic        en;
        logic        upd;
        logic [29:0] freq;
        logic [1:0]  state;
        logic [22:0] csec;
    } t_tone_report;

    // settings copy
    logic [29:0] cfg_base;
    logic [15:0] cfg_offset;
    logic [15:0] cfg_dur;
    logic [11:0] cfg_cycle;

    // sequencer copy
    logic [1:0]  seq_state;
    logic [7:0]  sym_ptr;
    logic [31:0] cycle_t0;
    logic [31:0] sym_t0;
    logic        msg_ready;
    logic        carrier_on;
    logic [1:0]  tone_store [0:MESSAGE_LENGTH-1];

    t_tone_report expected_reports [$];

    function automatic void launch_transmission(logic [31:0] now);
        seq_state  = TX_CODE_TX;
        sym_ptr    = '0;
        cycle_t0   = now;
        carrier_on = 1'b1;
    endfunction

    function automatic t_tone_report advance_sequencer(t_func op, logic [31:0] now,
                                                       logic [7:0] idx, logic [1:0] val,
                                                       logic done);
        t_tone_report rep;
        logic [47:0]  sum;
        logic [12:0]  step;
        logic [31:0]  since_cycle;
        rep = '0;
        case (op)
            FUNC_START: launch_transmission(now);
            FUNC_STOP: begin
                carrier_on = 1'b0;
                seq_state  = TX_CODE_IDLE;
            end
            FUNC_LOAD: begin
                if (idx < MESSAGE_LENGTH) tone_store[idx] = val;
                if (done) msg_ready = 1'b1;
            end
            FUNC_POLL: begin
                if (seq_state == TX_CODE_WAIT) begin
                    if ((now - cycle_t0) > 32'(cfg_cycle) * 32'd1000) launch_transmission(now);
                end else if (seq_state == TX_CODE_TX) begin
                    if (!msg_ready) begin
                        seq_state = TX_CODE_WAIT;
                    end else if (sym_ptr == 0 || (now - sym_t0) >= 32'(cfg_dur)) begin
                        sym_t0  = now;
                        rep.upd = 1'b1;
                        case (tone_store[sym_ptr])
                            2'd0: step = 13'd0;
                            2'd1: step = 13'd1465;
                            2'd2: step = 13'd2930;
                            default: step = 13'd4394;
                        endcase
                        sum = (48'(cfg_base) + 48'(cfg_offset)) * 48'd1000 + 48'(step);
                        rep.freq = (sum > 48'(FREQ_MAX)) ? FREQ_MAX : sum[29:0];
                        sym_ptr = sym_ptr + 8'd1;
                        // last symbol sounded: carrier off until the next cycle
                        if (sym_ptr >= MESSAGE_LENGTH) begin
                            carrier_on = 1'b0;
                            seq_state  = TX_CODE_WAIT;
                        end
                    end
                end
            end
            default: ;
        endcase
        since_cycle = now - cycle_t0;
        rep.en    = carrier_on;
        rep.state = seq_state;
        rep.csec  = 23'(since_cycle / 32'd1000);
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_tone_report want;
        if (!i_rst_n) begin
            cfg_base     = RST_BASE_FREQ;
            cfg_offset   = RST_OFFSET_FREQ;
            cfg_dur      = RST_SYMBOL_DUR;
            cfg_cycle    = RST_CYCLE_SEC;
            seq_state    = TX_CODE_IDLE;
            sym_ptr      = '0;
            cycle_t0     = '0;
            sym_t0       = '0;
            msg_ready    = 1'b0;
            carrier_on   = 1'b0;
            o_mismatches = 0;
            o_pending    = 0;
            expected_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_BASE_FREQ:   cfg_base   = pwdata[29:0];
                    REG_OFFSET_FREQ: cfg_offset = pwdata[15:0];
                    REG_SYMBOL_DUR:  cfg_dur    = pwdata[15:0];
                    REG_CYCLE_SEC:   cfg_cycle  = pwdata[11:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("report transfer with no item waiting for it");
                    o_mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_axis_tdata[0] !== want.en) begin
                        $error("carrier_enable: expected %0d, got %0d", want.en, m_axis_tdata[0]);
                        o_mismatches++;
                    end
                    if (m_axis_tuser !== want.upd) begin
                        $error("freq_update: expected %0d, got %0d", want.upd, m_axis_tuser);
                        o_mismatches++;
                    end
                    if (m_axis_tdata[30:1] !== want.freq) begin
                        $error("freq_millihz: expected %0d, got %0d", want.freq,
                               m_axis_tdata[30:1]);
                        o_mismatches++;
                    end
                    if (m_axis_tdata[32:31] !== want.state) begin
                        $error("tx_state: expected %0d, got %0d", want.state,
                               m_axis_tdata[32:31]);
                        o_mismatches++;
                    end
                    if (m_axis_tdata[55:33] !== want.csec) begin
                        $error("cycle_second: expected %0d, got %0d", want.csec,
                               m_axis_tdata[55:33]);
                        o_mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_reports.push_back(advance_sequencer(t_func'(s_axis_tuser),
                    s_axis_tdata[31:0], s_axis_tdata[39:32], s_axis_tdata[41:40],
                    s_axis_tlast));
            end
            o_pending = expected_reports.size();
        end
    end

endmodule

FILE: dv/tb_wspr_symbol_transmit_sequencer.sv
// ---------------------------------------------------------------------------
// tb_wspr_symbol_transmit_sequencer
// drives polls, starts, stops and symbol loads through the transmit
// sequencer under several carrier, hold and cycle settings, with random
// gaps and stalls on both streams; the checker scores every report
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wspr_symbol_transmit_sequencer;
    import wsts_pkg::*;

    localparam int LONG_HOLD = 120;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // now_ms, symbol_index, symbol_value, zero pad
    logic [1:0]  s_axis_tuser = FUNC_POLL;  // func
    logic        s_axis_tlast = 1'b0;  // load_done
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;  // carrier_enable, freq_millihz, tx_state, cycle_second
    logic        m_axis_tuser;  // freq_update
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned n_sent = 0;
    int unsigned n_recv = 0;
    int unsigned n_tones = 0;
    logic [31:0] t_now = '0;
    int unsigned tx_quiet = 0;
    int unsigned rx_quiet = 0;
    int unsigned rx_stall = 0;
    int unsigned hold_left = 0;
    bit          hold_request = 1'b0;
    bit          hold_taken = 1'b0;
    int          mismatches;
    int          pending;

    wspr_symbol_transmit_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    wsts_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(64'd4_000_000);
        $display("tb_wspr_symbol_transmit_sequencer: errors");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, quiet stretches and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (hold_request && !hold_taken) begin
            m_axis_tready <= 1'b0;
            hold_taken = 1'b1;
            hold_left = LONG_HOLD - 1;
        end else if (rx_stall != 0) begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_axis_tready <= 1'b1;
            if (rx_quiet != 0) rx_quiet--;
            else if ($urandom_range(0, 29) == 0) rx_quiet = $urandom_range(20, 80);
            else rx_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_recv <= n_recv + 1;
            if (m_axis_tuser) n_tones <= n_tones + 1;
        end
    end

    task automatic send_item(input t_func op, input logic [31:0] now, input logic [7:0] idx,
                             input logic [1:0] val, input logic done);
        int unsigned gap;
        if (tx_quiet != 0) begin
            tx_quiet--;
            gap = 0;
        end else if ($urandom_range(0, 29) == 0) begin
            tx_quiet = $urandom_range(20, 80);
            gap = 0;
        end else begin
            gap = pick_gap();
        end
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= done;
        s_axis_tdata  <= {6'b0, val, idx, now};
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (n_recv != n_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [31:0] base, input logic [31:0] offset,
                             input logic [31:0] dur, input logic [31:0] cyc);
        drain();
        write_reg(REG_BASE_FREQ, base);
        write_reg(REG_OFFSET_FREQ, offset);
        write_reg(REG_SYMBOL_DUR, dur);
        write_reg(REG_CYCLE_SEC, cyc);
    endtask

    // clock advance between polls, biased to the symbol and cycle boundaries
    function automatic logic [31:0] time_step(int unsigned dur, int unsigned cyc);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return dur;
        if (r < 55) return dur + $urandom_range(1, 5);
        if (r < 65) return (dur == 0) ? 0 : dur - 1;
        if (r < 80) return $urandom_range(0, 3);
        if (r < 95) return cyc * 1000 + $urandom_range(0, 2);
        return $urandom;
    endfunction

    task automatic run_phase(input int unsigned count, input int unsigned dur,
                             input int unsigned cyc);
        int unsigned r;
        bit          parked;
        logic [7:0]  li;
        parked = 1'b0;
        send_item(FUNC_START, t_now, 8'($urandom), 2'($urandom), 1'($urandom));
        for (int unsigned k = 1; k < count; k++) begin
            r = $urandom_range(0, 999);
            if (r < 6 || (parked && r < 130)) begin
                send_item(FUNC_START, t_now, 8'($urandom), 2'($urandom), 1'($urandom));
                parked = 1'b0;
            end else if (r < 10) begin
                send_item(FUNC_STOP, t_now, 8'($urandom), 2'($urandom), 1'($urandom));
                parked = 1'b1;
            end else if (r < 130) begin
                if ($urandom_range(0, 9) < 7) li = 8'($urandom_range(0, MESSAGE_LENGTH - 1));
                else li = 8'($urandom_range(MESSAGE_LENGTH, 255));
                t_now = t_now + $urandom_range(0, 2);
                send_item(FUNC_LOAD, t_now, li, 2'($urandom), 1'($urandom));
            end else begin
                t_now = t_now + time_step(dur, cyc);
                send_item(FUNC_POLL, t_now, 8'($urandom), 2'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        logic [31:0] rnd_base;
        logic [31:0] rnd_offset;
        logic [31:0] rnd_dur;
        logic [31:0] rnd_cycle;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no message yet: idle polls, wait timing, restart, wrap of the clock
        send_item(FUNC_POLL, 32'd0, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'hFFFF_FFFF, 8'hFF, 2'd3, 1'b1);
        send_item(FUNC_STOP, 32'd5, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_START, 32'd1000, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd1500, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd241000, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd241001, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd241002, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_LOAD, 32'd241003, 8'd255, 2'd3, 1'b0);
        send_item(FUNC_LOAD, 32'd241004, 8'd162, 2'd1, 1'b0);
        send_item(FUNC_START, 32'hFFFF_FF00, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'h0000_0100, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'h0003_AA00, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_STOP, 32'h0003_AA01, 8'd0, 2'd0, 1'b0);

        // fill the whole store before the message is marked complete
        t_now = 32'd2000;
        for (int i = 0; i < MESSAGE_LENGTH; i++) begin
            t_now = t_now + 1;
            send_item(FUNC_LOAD, t_now, i[7:0], 2'($urandom), 1'b0);
        end

        // out-of-range load completes the message; symbol hold boundary
        send_item(FUNC_LOAD, 32'd4990, 8'd200, 2'd2, 1'b1);
        send_item(FUNC_START, 32'd5000, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd5000, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd5681, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd5682, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_LOAD, 32'd5700, 8'd1, 2'd3, 1'b1);
        send_item(FUNC_START, 32'd6000, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd6000, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_STOP, 32'd6001, 8'd0, 2'd0, 1'b0);
        send_item(FUNC_POLL, 32'd7000, 8'd0, 2'd0, 1'b0);
        t_now = 32'd7000;

        // saturated carrier, every poll during transmission advances the symbol
        configure(32'd1000000000, 32'd65535, 32'd0, 32'd1);
        hold_request <= 1'b1;
        run_phase(140, 0, 1);

        // saturation edge between tones, longest hold and a long cycle
        configure(32'd1065000, 32'd538, 32'd65535, 32'd3600);
        run_phase(70, 65535, 3600);

        // bare tone steps, zero cycle length
        configure(32'd0, 32'd0, 32'd1, 32'd0);
        run_phase(140, 1, 0);

        rnd_base   = $urandom_range(0, 1066000);
        rnd_offset = $urandom_range(0, 65535);
        rnd_dur    = $urandom_range(1, 20);
        rnd_cycle  = $urandom_range(1, 3);
        configure(rnd_base, rnd_offset, rnd_dur, rnd_cycle);
        run_phase(120, rnd_dur, rnd_cycle);

        drain();
        repeat (8) @(posedge i_clk);
        $display("%0d items sent, %0d reports checked, %0d tone steps among them",
                 n_sent, n_recv, n_tones);
        $display("settings ran from saturated to bare tones, hold 0 to 65535 ms, cycle 0 to 3600 s");
        if (mismatches == 0 && pending == 0) begin
            $display("tb_wspr_symbol_transmit_sequencer: clean");
        end else begin
            $display("tb_wspr_symbol_transmit_sequencer: errors");
        end
        $finish;
    end

endmodule
